// ===== rtl/usc_pkg.sv =====
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types, command and status codes and the byte-wide CRC-32 update
// for the upload session checker.
// ----------------------------------------------------------------------------
package usc_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 4;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;

    // command codes
    localparam logic [OP_W-1:0] OP_BEGIN   = 3'd0;
    localparam logic [OP_W-1:0] OP_TARGET  = 3'd1;
    localparam logic [OP_W-1:0] OP_SIZE    = 3'd2;
    localparam logic [OP_W-1:0] OP_CRC     = 3'd3;
    localparam logic [OP_W-1:0] OP_DATA    = 3'd4;
    localparam logic [OP_W-1:0] OP_END     = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_READY         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TARGET        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_SIZE          = 4'd2;
    localparam logic [STATUS_W-1:0] ST_CRC           = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BYTE_OK       = 4'd4;
    localparam logic [STATUS_W-1:0] ST_CHUNK_OK      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DONE          = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NO_SESSION    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_SIZE_MISMATCH = 4'd9;
    localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH  = 4'd10;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // one command item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] value;
        logic [BYTE_W-1:0] data_byte;
        logic              chunk_last;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   received_count;
    } result_t;

    // reflected crc-32 update over one byte, eight shift steps
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/usc_in_reg.sv =====
// ----------------------------------------------------------------------------
// usc_in_reg
// Input register: holds one command item until the session stage takes it.
// ----------------------------------------------------------------------------
module usc_in_reg
    import usc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    // free when empty or when the held item leaves in this cycle
    assign in_ready = !valid_reg || cmd_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (cmd_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cmd_reg <= in_cmd;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== rtl/usc_session.sv =====
// ----------------------------------------------------------------------------
// usc_session
// Session state and per-item decision: flags, expected size and crc,
// byte count and running crc, updated once per fired item.
// ----------------------------------------------------------------------------
module usc_session
    import usc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  cmd_t    cmd,
    output result_t result
);

    logic              active_reg,   active_next;
    logic              target_reg,   target_next;
    logic [WORD_W-1:0] exp_bytes_reg, exp_bytes_next;
    logic [WORD_W-1:0] exp_crc_reg,   exp_crc_next;
    logic [WORD_W-1:0] count_reg,     count_next;
    logic [WORD_W-1:0] crc_reg,       crc_next;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   count_upd;
    logic                finish;

    // command decode and state update
    always_comb begin
        active_next    = active_reg;
        target_next    = target_reg;
        exp_bytes_next = exp_bytes_reg;
        exp_crc_next   = exp_crc_reg;
        count_upd      = count_reg;
        crc_next       = crc_reg;
        status         = ST_NO_SESSION;

        if (cmd.op == OP_BEGIN) begin
            active_next    = 1'b1;
            target_next    = 1'b0;
            exp_bytes_next = '0;
            exp_crc_next   = '0;
            count_upd      = '0;
            crc_next       = CRC_ONES;
            status         = ST_READY;
        end else if (active_reg) begin
            case (cmd.op)
                OP_TARGET: begin
                    target_next = 1'b1;
                    status      = ST_TARGET;
                end
                OP_SIZE: begin
                    exp_bytes_next = cmd.value;
                    status         = ST_SIZE;
                end
                OP_CRC: begin
                    exp_crc_next = cmd.value;
                    status       = ST_CRC;
                end
                OP_DATA: begin
                    if (!target_reg) begin
                        status = ST_NO_SESSION;
                    end else if (count_reg >= exp_bytes_reg) begin
                        status = ST_OVERFLOW;
                    end else begin
                        crc_next  = crc_byte(crc_reg, cmd.data_byte);
                        count_upd = count_reg + 32'd1;
                        status    = cmd.chunk_last ? ST_CHUNK_OK : ST_BYTE_OK;
                    end
                end
                OP_END: begin
                    if (count_reg != exp_bytes_reg) begin
                        status = ST_SIZE_MISMATCH;
                    end else if ((crc_reg ^ CRC_ONES) != exp_crc_reg) begin
                        status = ST_CRC_MISMATCH;
                    end else begin
                        status = ST_DONE;
                    end
                end
                default: begin
                    status = ST_NO_SESSION;
                end
            endcase
        end

        // every abort or finish drops the session
        finish = (status == ST_OVERFLOW) || (status == ST_SIZE_MISMATCH) ||
                 (status == ST_CRC_MISMATCH) || (status == ST_DONE);
        count_next = count_upd;
        if (finish) begin
            active_next    = 1'b0;
            target_next    = 1'b0;
            exp_bytes_next = '0;
            exp_crc_next   = '0;
            count_next     = '0;
            crc_next       = CRC_ONES;
        end
    end

    assign result.status         = status;
    assign result.received_count = count_upd;

    // session registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            target_reg    <= 1'b0;
            exp_bytes_reg <= '0;
            exp_crc_reg   <= '0;
            count_reg     <= '0;
            crc_reg       <= CRC_ONES;
        end else if (fire) begin
            active_reg    <= active_next;
            target_reg    <= target_next;
            exp_bytes_reg <= exp_bytes_next;
            exp_crc_reg   <= exp_crc_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

// ===== rtl/usc_out_reg.sv =====
// ----------------------------------------------------------------------------
// usc_out_reg
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module usc_out_reg
    import usc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_result,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // room when empty or when the held item leaves now
    assign can_load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== rtl/upload_session_crc_checker.sv =====
// ----------------------------------------------------------------------------
// upload_session_crc_checker
// Upload session checker with a running reflected crc-32, one command item
// in and one result item out.
//
//   channel   dir  tdata                         tuser        tlast
//   s_        in   [31:0] value, [39:32] byte    [2:0] op     chunk_last
//   m_        out  [31:0] received_count         [3:0] status -
//
// One item per cycle sustained while m_tready stays high; each item is held in the input
// register and its result is loaded into the result register when the item moves on.
// The byte-wide crc update and the count compare sit between those two
// registers and set the clock.
// Reset (aresetn low, synchronous) empties both registers and restores the
// session state; a stalled m_ side fills both registers and then holds
// s_tready low.
// ----------------------------------------------------------------------------
module upload_session_crc_checker
    import usc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], data_byte [39:32]
    input  logic [2:0]  s_tuser,   // op [2:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // received_count [31:0]
    output logic [3:0]  m_tuser    // status [3:0]
);

    cmd_t    in_cmd;
    cmd_t    cmd;
    logic    cmd_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t out_result;

    // unpack the input item
    assign in_cmd.op         = s_tuser;
    assign in_cmd.value      = s_tdata[31:0];
    assign in_cmd.data_byte  = s_tdata[39:32];
    assign in_cmd.chunk_last = s_tlast;

    // an item moves on when the result register has room
    assign fire = cmd_valid && can_load;

    usc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (fire),
        .cmd       (cmd)
    );

    usc_session u_session (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cmd     (cmd),
        .result  (result)
    );

    usc_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire),
        .load_result (result),
        .can_load    (can_load),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = out_result.received_count;
    assign m_tuser = out_result.status;

endmodule

// ===== rtl/usc_checker.sv =====
// ----------------------------------------------------------------------------
// usc_checker
// Port-level checks for the upload session checker, bound to the top level.
// ----------------------------------------------------------------------------
module usc_checker
    import usc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // result register is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a fresh session reports a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_READY) |-> m_tdata == 32'd0)
        else $error("begin with nonzero count");

    // an accepted byte always leaves a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == ST_BYTE_OK) || (m_tuser == ST_CHUNK_OK))
        |-> m_tdata != 32'd0)
        else $error("byte accepted with zero count");

    // status stays within the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_CRC_MISMATCH)
        else $error("undefined status code");

endmodule

bind upload_session_crc_checker usc_checker u_usc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
